/* sv/smavg_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// smavg_pkg
// Shared types and constants of the moving average unit: register width and
// the sequencer state encoding.
// ---------------------------------------------------------------------------
package smavg_pkg;

	// Width of the window length register
	localparam int WIN_BITS = 7;

	// Sequencer states of the top level
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DIVIDE,
		ST_OUTPUT
	} state_t;

endpackage
`default_nettype wire

/* sv/smavg_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// smavg_if
// Valid/ready channels of the moving average unit: sample words in, result
// words out, and the window length write port.
// ---------------------------------------------------------------------------

// Sample channel
interface smavg_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          run_start;
	logic                          run_end;

	modport source (output valid, sample, run_start, run_end, input ready);
	modport sink   (input valid, sample, run_start, run_end, output ready);
endinterface

// Result channel
interface smavg_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] average;
	logic                          short_run;
	logic                          last_of_run;

	modport source (output valid, average, short_run, last_of_run, input ready);
	modport sink   (input valid, average, short_run, last_of_run, output ready);
endinterface

// Window length write channel
interface smavg_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [smavg_pkg::WIN_BITS-1:0]     window_length;

	modport source (output valid, window_length, input ready);
	modport sink   (input valid, window_length, output ready);
endinterface
`default_nettype wire

/* sv/smavg_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// smavg_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module smavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* sv/smavg_div.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// smavg_div
// Iterative restoring divider for unsigned operands: one quotient bit per
// cycle, done pulses once when finished.
// ---------------------------------------------------------------------------
module smavg_div #(
	parameter int DVD_BITS = 22,
	parameter int DVS_BITS = 7
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [DVD_BITS-1:0] dividend,
	input  wire logic [DVS_BITS-1:0] divisor,
	output logic                     done,
	output logic      [DVD_BITS-1:0] quotient
);

	localparam int CNT_BITS = $clog2(DVD_BITS + 1);

	logic [DVD_BITS-1:0] dvd_q;
	logic [DVS_BITS-1:0] rem_q;
	logic [DVS_BITS-1:0] dvs_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;
	logic [DVS_BITS:0]   shifted;
	logic [DVS_BITS:0]   trial;
	logic                fits;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		shifted = {rem_q, dvd_q[DVD_BITS-1]};
		fits    = shifted >= {1'b0, dvs_q};
		trial   = shifted - {1'b0, dvs_q};
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_BITS'(1));
			if (start) begin
				cnt_q <= CNT_BITS'(DVD_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
		end
	end

	// Datapath: dividend register turns into the quotient bit by bit
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DVD_BITS-2:0], fits};
			rem_q <= fits ? trial[DVS_BITS-1:0] : shifted[DVS_BITS-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
`default_nettype wire

/* sv/simple_moving_average_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// simple_moving_average_unit
// Moving average over the last window_length samples, kept as a running sum
// over a sample ring, with the average produced by a shared divider.
// ---------------------------------------------------------------------------
// One sample word is taken at a time. From acceptance, a word that produces
// an average passes the read, update and divide states before the result
// word is valid, the restoring divider retiring one quotient bit per cycle
// of a SUM_BITS = SAMPLE_BITS + log2(MAX_WINDOW) dividend; the next sample
// can be taken in the cycle after the result word is taken. A word that
// ends a run before the window has filled gives its short-run result after
// the read and update states, and a word that gives no result frees the
// unit after the same states. Writing window_length, or a sample with
// run_start set, empties the window. A window length of 0 acts as 1 and a
// length above MAX_WINDOW acts as MAX_WINDOW. The configuration port is
// always ready and must only be written while the unit is idle.
// ---------------------------------------------------------------------------
module simple_moving_average_unit #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	smavg_in_if.sink   samples,
	smavg_out_if.source averages,
	smavg_cfg_if.sink  setup
);

	localparam int WIN_BITS  = smavg_pkg::WIN_BITS;
	localparam int PTR_BITS  = $clog2(MAX_WINDOW);
	localparam int FILL_BITS = $clog2(MAX_WINDOW + 1);
	localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW);
	localparam int DIF_BITS  = $clog2(MAX_WINDOW) + 2;
	localparam int EXT_BITS  = SUM_BITS - SAMPLE_BITS;

	smavg_pkg::state_t state_q, state_d;

	// Window state
	logic [WIN_BITS-1:0]        window_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic [FILL_BITS-1:0]       fill_q;
	logic [PTR_BITS-1:0]        wp_q;

	// Per-item registers
	logic [SAMPLE_BITS-1:0]     sample_q;
	logic                       end_q;
	logic [WIN_BITS-1:0]        w_q;
	logic                       neg_q;

	// Result registers
	logic [SAMPLE_BITS-1:0]     avg_q;
	logic                       short_q;
	logic                       last_q;

	// Combinational
	logic [WIN_BITS-1:0]        eff_w;
	logic                       accept;
	logic                       use_old;
	logic [DIF_BITS-1:0]        wrap_idx;
	logic [PTR_BITS-1:0]        old_idx;
	logic [SAMPLE_BITS-1:0]     old_sample;
	logic signed [SUM_BITS-1:0] old_ext;
	logic signed [SUM_BITS-1:0] new_ext;
	logic signed [SUM_BITS-1:0] sum_nx;
	logic [FILL_BITS-1:0]       fill_nx;
	logic [PTR_BITS-1:0]        wp_nx;
	logic                       full_nx;
	logic [SUM_BITS-1:0]        sum_mag;
	logic [SUM_BITS-1:0]        quot;
	logic [SUM_BITS-1:0]        quot_signed;
	logic                       div_done;
	logic                       rd_en;
	logic                       wr_en;
	logic                       div_start;

	assign accept        = samples.valid && samples.ready;
	assign samples.ready = (state_q == smavg_pkg::ST_IDLE);
	assign setup.ready   = 1'b1;

	// Clamp the window length into 1 .. MAX_WINDOW
	always_comb begin
		eff_w = window_q;
		if (window_q == '0) begin
			eff_w = WIN_BITS'(1);
		end else if (int'(window_q) > MAX_WINDOW) begin
			eff_w = WIN_BITS'(MAX_WINDOW);
		end
	end

	// Locate the sample that leaves the window
	always_comb begin
		use_old  = int'(fill_q) >= int'(w_q);
		wrap_idx = DIF_BITS'(wp_q) + DIF_BITS'(MAX_WINDOW) - DIF_BITS'(w_q);
		if (wrap_idx >= DIF_BITS'(MAX_WINDOW)) begin
			wrap_idx = wrap_idx - DIF_BITS'(MAX_WINDOW);
		end
		old_idx = wrap_idx[PTR_BITS-1:0];
	end

	// Running sum, fill count and write pointer after this sample
	always_comb begin
		old_ext = use_old ? {{EXT_BITS{old_sample[SAMPLE_BITS-1]}}, old_sample}
		                  : '0;
		new_ext = {{EXT_BITS{sample_q[SAMPLE_BITS-1]}}, sample_q};
		sum_nx  = sum_q - old_ext + new_ext;
		fill_nx = (int'(fill_q) < MAX_WINDOW) ? fill_q + FILL_BITS'(1) : fill_q;
		wp_nx   = (int'(wp_q) == MAX_WINDOW - 1) ? '0 : wp_q + PTR_BITS'(1);
		full_nx = int'(fill_nx) >= int'(w_q);
		sum_mag = sum_nx[SUM_BITS-1] ? SUM_BITS'(-sum_nx) : SUM_BITS'(sum_nx);
		quot_signed = neg_q ? -quot : quot;
	end

	// Sequencer: next state and strobes
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			smavg_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = smavg_pkg::ST_READ;
				end
			end
			smavg_pkg::ST_READ: begin
				rd_en   = 1'b1;
				state_d = smavg_pkg::ST_UPDATE;
			end
			smavg_pkg::ST_UPDATE: begin
				wr_en = 1'b1;
				if (full_nx) begin
					div_start = 1'b1;
					state_d   = smavg_pkg::ST_DIVIDE;
				end else if (end_q) begin
					state_d = smavg_pkg::ST_OUTPUT;
				end else begin
					state_d = smavg_pkg::ST_IDLE;
				end
			end
			smavg_pkg::ST_DIVIDE: begin
				if (div_done) begin
					state_d = smavg_pkg::ST_OUTPUT;
				end
			end
			smavg_pkg::ST_OUTPUT: begin
				if (averages.ready) begin
					state_d = smavg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = smavg_pkg::ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smavg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Window state: clear on register write or run start, advance on update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_BITS'(1);
			sum_q    <= '0;
			fill_q   <= '0;
			wp_q     <= '0;
		end else begin
			if (setup.valid && setup.ready) begin
				window_q <= setup.window_length;
				sum_q    <= '0;
				fill_q   <= '0;
				wp_q     <= '0;
			end else if (accept && samples.run_start) begin
				sum_q  <= '0;
				fill_q <= '0;
				wp_q   <= '0;
			end else if (state_q == smavg_pkg::ST_UPDATE) begin
				sum_q  <= sum_nx;
				fill_q <= fill_nx;
				wp_q   <= wp_nx;
			end
		end
	end

	// Hold the accepted word and the sign of the new sum
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= samples.sample;
			end_q    <= samples.run_end;
			w_q      <= eff_w;
		end
		if (state_q == smavg_pkg::ST_UPDATE) begin
			neg_q <= sum_nx[SUM_BITS-1];
		end
	end

	// Result word: short run error or signed quotient
	always_ff @(posedge clk) begin
		if (state_q == smavg_pkg::ST_UPDATE && !full_nx && end_q) begin
			avg_q   <= '0;
			short_q <= 1'b1;
			last_q  <= 1'b1;
		end else if (state_q == smavg_pkg::ST_DIVIDE && div_done) begin
			avg_q   <= quot_signed[SAMPLE_BITS-1:0];
			short_q <= 1'b0;
			last_q  <= end_q;
		end
	end

	assign averages.valid       = (state_q == smavg_pkg::ST_OUTPUT);
	assign averages.average     = avg_q;
	assign averages.short_run   = short_q;
	assign averages.last_of_run = last_q;

	// Sample ring
	smavg_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (sample_q),
		.rd_en   (rd_en),
		.rd_addr (old_idx),
		.rd_data (old_sample)
	);

	// Shared divider: |sum| / window
	smavg_div #(
		.DVD_BITS (SUM_BITS),
		.DVS_BITS (WIN_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_mag),
		.divisor  (w_q),
		.done     (div_done),
		.quotient (quot)
	);

endmodule
`default_nettype wire

/* verif/simple_moving_average_unit_test.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// simple_moving_average_unit_test
// Self-checking bench for the moving average unit. A short table of directed
// words and window settings runs first, then random runs of samples over
// several window lengths, with random idle bursts on both channels and one
// long hold on the result side. Every accepted sample word goes through a
// running-sum model of the window, and every result word is compared against
// the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module simple_moving_average_unit_test;

	localparam int WIN_BITS     = smavg_pkg::WIN_BITS;
	localparam int MAX_WINDOW   = 64;
	localparam int SAMPLE_BITS  = 16;
	localparam int RANDOM_WORDS = 1650;
	localparam int SETTLE       = 10;
	localparam int DRAIN        = 60;
	localparam int LONG_HOLD    = 300;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] average;
		logic                          short_run;
		logic                          last_of_run;
	} avg_word_t;

	typedef enum logic {ROW_WORD, ROW_WRITE} row_kind_t;

	// One directed step: a sample word or a window length write
	typedef struct packed {
		row_kind_t           kind;
		logic signed [31:0]  value;
		logic                run_start;
		logic                run_end;
		logic                typed;
		logic signed [15:0]  exp_avg;
		logic                exp_short;
		logic                exp_last;
	} row_t;

	localparam int DIRECTED_COUNT = 23;
	localparam row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// window of 1 after reset: each word is its own average
		'{ROW_WORD,   32767, 1'b1, 1'b0, 1'b1,  32767, 1'b0, 1'b0},
		'{ROW_WORD,  -32768, 1'b0, 1'b0, 1'b1, -32768, 1'b0, 1'b0},
		'{ROW_WORD,      -1, 1'b0, 1'b1, 1'b1,     -1, 1'b0, 1'b1},
		'{ROW_WORD,       0, 1'b1, 1'b1, 1'b1,      0, 1'b0, 1'b1},
		// zero length acts as one
		'{ROW_WRITE,      0, 1'b0, 1'b0, 1'b0,      0, 1'b0, 1'b0},
		'{ROW_WORD,   12345, 1'b0, 1'b1, 1'b1,  12345, 1'b0, 1'b1},
		// short run, truncation toward zero, sliding across a run boundary
		'{ROW_WRITE,      2, 1'b0, 1'b0, 1'b0,      0, 1'b0, 1'b0},
		'{ROW_WORD,       5, 1'b1, 1'b1, 1'b1,      0, 1'b1, 1'b1},
		'{ROW_WORD,       7, 1'b1, 1'b0, 1'b0,      0, 1'b0, 1'b0},
		'{ROW_WORD,      -8, 1'b0, 1'b0, 1'b0,      0, 1'b0, 1'b0},
		'{ROW_WORD,      -3, 1'b0, 1'b1, 1'b0,      0, 1'b0, 1'b0},
		'{ROW_WORD,       4, 1'b0, 1'b0, 1'b0,      0, 1'b0, 1'b0},
		// oversized length saturates; the write empties the window
		'{ROW_WRITE,    127, 1'b0, 1'b0, 1'b0,      0, 1'b0, 1'b0},
		'{ROW_WORD,  -32768, 1'b0, 1'b1, 1'b1,      0, 1'b1, 1'b1},
		// full-scale sums in a window of three
		'{ROW_WRITE,      3, 1'b0, 1'b0, 1'b0,      0, 1'b0, 1'b0},
		'{ROW_WORD,   32767, 1'b1, 1'b0, 1'b0,      0, 1'b0, 1'b0},
		'{ROW_WORD,   32767, 1'b0, 1'b0, 1'b0,      0, 1'b0, 1'b0},
		'{ROW_WORD,   32767, 1'b0, 1'b0, 1'b1,  32767, 1'b0, 1'b0},
		'{ROW_WORD,  -32768, 1'b0, 1'b0, 1'b0,      0, 1'b0, 1'b0},
		'{ROW_WORD,  -32768, 1'b0, 1'b0, 1'b0,      0, 1'b0, 1'b0},
		'{ROW_WORD,  -32768, 1'b0, 1'b1, 1'b1, -32768, 1'b0, 1'b1},
		// just above the ring depth
		'{ROW_WRITE,     65, 1'b0, 1'b0, 1'b0,      0, 1'b0, 1'b0},
		'{ROW_WORD,       1, 1'b1, 1'b1, 1'b1,      0, 1'b1, 1'b1}
	};

	logic clk = 1'b0;
	logic arst_n;

	smavg_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) samples_if ();
	smavg_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) averages_if ();
	smavg_cfg_if                              setup_if ();

	simple_moving_average_unit #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.averages(averages_if),
		.setup   (setup_if)
	);

	// Window model
	logic signed [SAMPLE_BITS-1:0] window_ring [MAX_WINDOW];
	longint                        window_sum;
	int                            window_fill;
	int                            ring_head;
	logic [WIN_BITS-1:0]           window_reg;

	avg_word_t pending_averages [$];
	int        error_count;
	int        random_words;
	bit        gaps_enabled;
	bit        hold_results_req;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int active_window();
		if (window_reg == 0)
			return 1;
		if (window_reg > MAX_WINDOW)
			return MAX_WINDOW;
		return int'(window_reg);
	endfunction

	function automatic void empty_window();
		window_sum  = 0;
		window_fill = 0;
		ring_head   = 0;
	endfunction

	// Advance the window by one sample and work out the result word, if any
	task automatic predict_average(
		input  logic signed [SAMPLE_BITS-1:0] s,
		input  logic                          start,
		input  logic                          fin,
		output bit                            produced,
		output avg_word_t                     word
	);
		int     w;
		int     oldest;
		longint quotient;
		w = active_window();
		if (start)
			empty_window();
		if (window_fill >= w) begin
			oldest = (ring_head + MAX_WINDOW - w) % MAX_WINDOW;
			window_sum -= window_ring[oldest];
		end
		window_sum += s;
		window_ring[ring_head] = s;
		ring_head = (ring_head + 1) % MAX_WINDOW;
		if (window_fill < MAX_WINDOW)
			window_fill++;
		produced = 1'b0;
		word     = '0;
		if (window_fill >= w) begin
			quotient         = window_sum / w;
			word.average     = quotient[SAMPLE_BITS-1:0];
			word.last_of_run = fin;
			produced         = 1'b1;
		end else if (fin) begin
			word.short_run   = 1'b1;
			word.last_of_run = 1'b1;
			produced         = 1'b1;
		end
	endtask

	function automatic void report_error(string what, avg_word_t want, avg_word_t got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%s: expected avg=%0d short=%0b last=%0b, got avg=%0d short=%0b last=%0b",
				what, want.average, want.short_run, want.last_of_run,
				got.average, got.short_run, got.last_of_run);
	endfunction

	// Offer one sample word, with an occasional idle burst before it
	task automatic send_word(
		input logic signed [SAMPLE_BITS-1:0] s,
		input logic                          start,
		input logic                          fin,
		input bit                            typed,
		input avg_word_t                     typed_word
	);
		bit        produced;
		avg_word_t word;
		if (gaps_enabled && $urandom_range(0, 3) == 0) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		samples_if.valid     <= 1'b1;
		samples_if.sample    <= s;
		samples_if.run_start <= start;
		samples_if.run_end   <= fin;
		do @(posedge clk); while (!samples_if.ready);
		predict_average(s, start, fin, produced, word);
		if (typed)
			pending_averages.push_back(typed_word);
		else if (produced)
			pending_averages.push_back(word);
	endtask

	// Drop valid and wait until the unit has gone quiet
	task automatic settle_idle(input int extra);
		samples_if.valid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_window(input logic [WIN_BITS-1:0] len);
		settle_idle(SETTLE);
		setup_if.valid         <= 1'b1;
		setup_if.window_length <= len;
		do @(posedge clk); while (!setup_if.ready);
		setup_if.valid <= 1'b0;
		window_reg = len;
		empty_window();
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(0, 5))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2, 3:    return SAMPLE_BITS'($urandom_range(0, 200)) - 16'sd100;
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// Check each result word against the oldest prediction
	always @(posedge clk) begin
		avg_word_t got;
		avg_word_t want;
		if (arst_n && averages_if.valid && averages_if.ready) begin
			got = '{averages_if.average, averages_if.short_run, averages_if.last_of_run};
			if (pending_averages.size() == 0) begin
				report_error("unexpected result word", '0, got);
			end else begin
				want = pending_averages.pop_front();
				if (got.average !== want.average || got.short_run !== want.short_run ||
						got.last_of_run !== want.last_of_run)
					report_error("result word mismatch", want, got);
			end
		end
	end

	// Result side: random stalls, one long hold on request, steady at the end
	initial begin
		averages_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_results_req) begin
				hold_results_req = 1'b0;
				averages_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (gaps_enabled && $urandom_range(0, 3) == 0) begin
				averages_if.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				averages_if.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// Guard against a hung run
	initial begin
		#6_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Stimulus
	initial begin
		row_t                          row;
		avg_word_t                     typed_word;
		int                            phase;
		int                            phase_words;
		int                            w;
		int                            run_len;
		logic [WIN_BITS-1:0]           next_len;
		int                            window_plan [12];

		window_plan  = '{1, 64, 2, 0, 127, 3, 65, 8, 5, 16, 33, 4};
		error_count  = 0;
		random_words = 0;
		gaps_enabled = 1'b1;
		hold_results_req = 1'b0;
		window_reg   = 1;
		empty_window();

		arst_n                 = 1'b0;
		samples_if.valid       <= 1'b0;
		samples_if.sample      <= '0;
		samples_if.run_start   <= 1'b0;
		samples_if.run_end     <= 1'b0;
		setup_if.valid         <= 1'b0;
		setup_if.window_length <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			row = DIRECTED_ROWS[i];
			if (row.kind == ROW_WRITE) begin
				write_window(row.value[WIN_BITS-1:0]);
			end else begin
				typed_word = '{row.exp_avg, row.exp_short, row.exp_last};
				send_word(row.value[SAMPLE_BITS-1:0], row.run_start, row.run_end,
					row.typed, typed_word);
			end
		end

		// Random phases, one window setting each
		phase = 0;
		while (random_words < RANDOM_WORDS) begin
			if (phase < 12)
				next_len = WIN_BITS'(window_plan[phase]);
			else if ($urandom_range(0, 3) == 0)
				next_len = WIN_BITS'($urandom_range(0, 127));
			else
				next_len = WIN_BITS'($urandom_range(1, 10));
			write_window(next_len);
			w = active_window();
			if (phase == 2)
				hold_results_req = 1'b1;
			phase_words = 0;
			while (phase_words < 150 && random_words < RANDOM_WORDS) begin
				if (random_words >= RANDOM_WORDS - 250)
					gaps_enabled = 1'b0;
				if ($urandom_range(0, 9) < 8) begin
					// well-formed run, now and then a short one
					if (w > 1 && $urandom_range(0, 4) == 0)
						run_len = $urandom_range(1, w - 1);
					else
						run_len = $urandom_range(w, w + 30);
					for (int k = 0; k < run_len; k++)
						send_word(random_sample(),
							(k == 0) && ($urandom_range(0, 9) != 0),
							k == run_len - 1, 1'b0, '0);
					phase_words  += run_len;
					random_words += run_len;
				end else begin
					// noise: flags at random
					run_len = $urandom_range(1, 4);
					for (int k = 0; k < run_len; k++)
						send_word(random_sample(), $urandom_range(0, 7) == 0,
							$urandom_range(0, 3) == 0, 1'b0, '0);
					phase_words  += run_len;
					random_words += run_len;
				end
			end
			phase++;
		end

		settle_idle(DRAIN);
		if (error_count == 0 && pending_averages.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
